FILE: rtl/core/swd_host_transfer_sequencer_unit_assert.svh
// Assertion macros for the SWD host transfer sequencer
`ifndef SWD_HOST_TRANSFER_SEQUENCER_UNIT_ASSERT_SVH
`define SWD_HOST_TRANSFER_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define SWD_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("swd sequencer: check failed");

// next-cycle implication
`define SWD_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("swd sequencer: check failed");

`endif

FILE: rtl/core/swd_pkg.sv
// Types and constants shared by the SWD host transfer sequencer
`timescale 1ns / 1ps

package swd_pkg;

  localparam int unsigned CNT_W = 6;

  // item ops
  localparam logic OP_START = 1'b0;
  localparam logic OP_CLOCK = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRN_CYCLES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_DATA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_COUNT = 2'd2;

  // sequencer phases
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_REQ     = 4'd1;
  localparam logic [3:0] PH_TRN1    = 4'd2;
  localparam logic [3:0] PH_ACK     = 4'd3;
  localparam logic [3:0] PH_TRN2    = 4'd4;
  localparam logic [3:0] PH_WDATA   = 4'd5;
  localparam logic [3:0] PH_RDATA   = 4'd6;
  localparam logic [3:0] PH_TRN3    = 4'd7;
  localparam logic [3:0] PH_IDLECYC = 4'd8;
  localparam logic [3:0] PH_RELEASE = 4'd9;

  // ack codes, first received bit in bit 0
  localparam logic [2:0] ACK_NONE  = 3'b000;
  localparam logic [2:0] ACK_OK    = 3'b001;
  localparam logic [2:0] ACK_WAIT  = 3'b010;
  localparam logic [2:0] ACK_FAULT = 3'b100;

  // header: start and park bits set
  localparam logic [7:0]  HDR_BASE   = 8'h81;
  localparam logic [15:0] PARITY_LUT = 16'h6996;

  localparam logic [CNT_W-1:0] REQ_BITS   = 6'd8;
  localparam logic [CNT_W-1:0] ACK_BITS   = 6'd3;
  localparam logic [CNT_W-1:0] DATA_BITS  = 6'd32;
  localparam logic [CNT_W-1:0] FRAME_BITS = 6'd33;

  localparam logic [2:0] TRN_MIN = 3'd1;
  localparam logic [2:0] TRN_MAX = 3'd4;

  typedef struct packed {
    logic        op;
    logic [3:0]  request_bits;
    logic [31:0] write_word;
    logic        line_sample;
  } in_t;

  typedef struct packed {
    logic        drive_level;
    logic        drive_enable;
    logic        transfer_done;
    logic [2:0]  ack_code;
    logic [31:0] read_word;
    logic        parity_error;
    logic        busy_res;
  } out_t;

  typedef struct packed {
    logic [2:0] trn_len;
    logic       force_data;
    logic [7:0] idle_count;
  } cfg_t;

endpackage

FILE: rtl/core/swd_cfg.sv
// Configuration registers with turnaround length clamp
`timescale 1ns / 1ps

module swd_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [swd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_data_i,
  output swd_pkg::cfg_t                 cfg_o
);

  logic [2:0] trn_q;
  logic       force_q;
  logic [7:0] idle_q;
  logic       wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trn_q   <= swd_pkg::TRN_MIN;
      force_q <= 1'b0;
      idle_q  <= 8'd0;
    end else if (wr) begin
      if (cfg_index_i == swd_pkg::CFG_TRN_CYCLES) begin
        trn_q <= cfg_data_i[2:0];
      end
      if (cfg_index_i == swd_pkg::CFG_FORCE_DATA) begin
        force_q <= cfg_data_i[0];
      end
      if (cfg_index_i == swd_pkg::CFG_IDLE_COUNT) begin
        idle_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    cfg_o.force_data = force_q;
    cfg_o.idle_count = idle_q;
    priority if (trn_q < swd_pkg::TRN_MIN) begin
      cfg_o.trn_len = swd_pkg::TRN_MIN;
    end else if (trn_q > swd_pkg::TRN_MAX) begin
      cfg_o.trn_len = swd_pkg::TRN_MAX;
    end else begin
      cfg_o.trn_len = trn_q;
    end
  end

endmodule

FILE: rtl/core/swd_core.sv
// Sequencer state and one-bit step logic
`timescale 1ns / 1ps

module swd_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  swd_pkg::in_t  item_i,
  input  swd_pkg::cfg_t cfg_i,
  output logic          res_valid_o,
  output swd_pkg::out_t res_o
);

  logic [3:0]                ph_q, ph_d;
  logic [swd_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_inc, trn;
  logic [7:0]                idl_q, idl_d;
  logic [31:0]               shf_q, shf_d;
  logic [3:0]                req_q, req_d;
  logic [2:0]                ack_q, ack_d, ack_sh;
  logic                      par_q, par_d;

  logic       lvl, en, busy, done, rd, ok, wf, ok_n, wf_n, s;
  logic [7:0] hdr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= swd_pkg::PH_IDLE;
      cnt_q <= '0;
      idl_q <= '0;
      shf_q <= '0;
      req_q <= '0;
      ack_q <= swd_pkg::ACK_NONE;
      par_q <= 1'b0;
    end else begin
      ph_q  <= ph_d;
      cnt_q <= cnt_d;
      idl_q <= idl_d;
      shf_q <= shf_d;
      req_q <= req_d;
      ack_q <= ack_d;
      par_q <= par_d;
    end
  end

  assign s       = item_i.line_sample;
  assign cnt_inc = cnt_q + 6'd1;
  assign trn     = {3'b000, cfg_i.trn_len};
  assign rd      = req_q[1];
  assign ok      = (ack_q == swd_pkg::ACK_OK);
  assign wf      = (ack_q == swd_pkg::ACK_WAIT) || (ack_q == swd_pkg::ACK_FAULT);
  assign ack_sh  = {s, ack_q[2:1]};
  assign ok_n    = (ack_sh == swd_pkg::ACK_OK);
  assign wf_n    = (ack_sh == swd_pkg::ACK_WAIT) || (ack_sh == swd_pkg::ACK_FAULT);
  assign hdr     = swd_pkg::HDR_BASE | {3'b000, req_q, 1'b0}
                 | {2'b00, swd_pkg::PARITY_LUT[req_q], 5'b00000};

  always_comb begin
    ph_d  = ph_q;
    cnt_d = cnt_q;
    idl_d = idl_q;
    shf_d = shf_q;
    req_d = req_q;
    ack_d = ack_q;
    par_d = par_q;
    lvl   = 1'b0;
    en    = 1'b0;
    busy  = 1'b1;
    if (step_i && item_i.op == swd_pkg::OP_START) begin
      if (ph_q == swd_pkg::PH_IDLE) begin
        req_d = item_i.request_bits;
        shf_d = item_i.write_word;
        par_d = 1'b0;
        ack_d = swd_pkg::ACK_NONE;
        idl_d = cfg_i.idle_count;
        ph_d  = swd_pkg::PH_REQ;
        cnt_d = '0;
      end
    end else if (step_i) begin
      cnt_d = cnt_inc;
      unique case (ph_q)
        swd_pkg::PH_REQ: begin
          en  = 1'b1;
          lvl = hdr[cnt_q[2:0]];
          if (cnt_inc >= swd_pkg::REQ_BITS) begin
            ph_d  = swd_pkg::PH_TRN1;
            cnt_d = '0;
          end
        end
        swd_pkg::PH_TRN1: begin
          if (cnt_inc >= trn) begin
            ph_d  = swd_pkg::PH_ACK;
            cnt_d = '0;
          end
        end
        swd_pkg::PH_ACK: begin
          ack_d = ack_sh;
          if (cnt_inc >= swd_pkg::ACK_BITS) begin
            cnt_d = '0;
            priority if (!rd) begin
              ph_d = swd_pkg::PH_TRN2;
            end else if (ok_n) begin
              ph_d = swd_pkg::PH_RDATA;
            end else if (wf_n) begin
              ph_d = cfg_i.force_data ? swd_pkg::PH_RDATA : swd_pkg::PH_TRN3;
            end else begin
              ph_d = swd_pkg::PH_RELEASE;
            end
          end
        end
        swd_pkg::PH_TRN2: begin
          if (cnt_inc >= trn) begin
            cnt_d = '0;
            priority if (ok) begin
              ph_d = swd_pkg::PH_WDATA;
            end else if (wf) begin
              ph_d = cfg_i.force_data ? swd_pkg::PH_WDATA : swd_pkg::PH_IDLE;
            end else begin
              ph_d = swd_pkg::PH_RELEASE;
            end
          end
        end
        swd_pkg::PH_WDATA: begin
          en = 1'b1;
          if (ok) begin
            if (cnt_q < swd_pkg::DATA_BITS) begin
              lvl   = shf_q[0];
              par_d = par_q ^ shf_q[0];
              shf_d = {1'b0, shf_q[31:1]};
            end else begin
              lvl = par_q;
            end
          end
          if (cnt_inc >= swd_pkg::FRAME_BITS) begin
            cnt_d = '0;
            if (ok && idl_q != 8'd0) begin
              ph_d = swd_pkg::PH_IDLECYC;
            end else begin
              ph_d = swd_pkg::PH_IDLE;
            end
          end
        end
        swd_pkg::PH_RDATA: begin
          if (cnt_q < swd_pkg::DATA_BITS) begin
            shf_d = {s, shf_q[31:1]};
          end
          par_d = par_q ^ s;
          if (cnt_inc >= swd_pkg::FRAME_BITS) begin
            ph_d  = swd_pkg::PH_TRN3;
            cnt_d = '0;
          end
        end
        swd_pkg::PH_TRN3: begin
          if (cnt_inc >= trn) begin
            cnt_d = '0;
            if (ok && idl_q != 8'd0) begin
              ph_d = swd_pkg::PH_IDLECYC;
            end else begin
              ph_d = swd_pkg::PH_IDLE;
            end
          end
        end
        swd_pkg::PH_IDLECYC: begin
          en    = 1'b1;
          cnt_d = cnt_q;
          if (idl_q != 8'd0) begin
            idl_d = idl_q - 8'd1;
          end
          if (idl_d == 8'd0) begin
            ph_d  = swd_pkg::PH_IDLE;
            cnt_d = '0;
          end
        end
        swd_pkg::PH_RELEASE: begin
          if (cnt_inc >= swd_pkg::FRAME_BITS + trn) begin
            ph_d  = swd_pkg::PH_IDLE;
            cnt_d = '0;
          end
        end
        default: begin
          ph_d  = swd_pkg::PH_IDLE;
          cnt_d = cnt_q;
          busy  = 1'b0;
          en    = 1'b1;
        end
      endcase
    end
  end

  assign done        = busy && (ph_d == swd_pkg::PH_IDLE);
  assign res_valid_o = step_i && (item_i.op == swd_pkg::OP_CLOCK);

  always_comb begin
    res_o.drive_level   = lvl;
    res_o.drive_enable  = en;
    res_o.transfer_done = done;
    res_o.ack_code      = done ? ack_d : swd_pkg::ACK_NONE;
    res_o.read_word     = (done && rd && ok) ? shf_d : 32'd0;
    res_o.parity_error  = done && rd && ok && par_d;
    res_o.busy_res      = busy;
  end

endmodule

FILE: rtl/core/swd_host_transfer_sequencer_unit.sv
// Top level of the SWD host transfer sequencer
//
// Input channel (in_valid_i / in_stall_o / in_data_i): a start item latches the
// request bits and write word when no transfer runs (ignored otherwise) and
// gives no result. Each clock item stands for one SWCLK cycle: it carries the
// sampled SWDIO level and gives exactly one result with the level and enable
// to drive in that cycle, plus done, ack, read data and parity error status.
// Output channel (out_valid_o / out_stall_i / out_data_o) carries results.
// Configuration (cfg_valid_i / cfg_ready_o): index 0 turnaround length,
// 1 forced data phase, 2 idle cycles after an OK transfer; always ready.
// A clock item passes from the input register through one step of sequencer
// logic into the output register, which presents its result.
// Throughput: one item per cycle while no result is stalled; the phase and bit
// counter registers step once per item. A stalled result stays in the output
// register while the next item waits in the input register; start items move on
// regardless. Reset empties both registers and returns the sequencer to idle
// with the minimum turnaround length, no forced data phase and no idle cycles.
`timescale 1ns / 1ps
`include "swd_host_transfer_sequencer_unit_assert.svh"

module swd_host_transfer_sequencer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  swd_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output swd_pkg::out_t                 out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [swd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_data_i
);

  swd_pkg::cfg_t cfg;
  swd_pkg::in_t  in_q;
  swd_pkg::out_t out_q, res;
  logic          in_vld_q, out_vld_q;
  logic          advance, accept, res_vld;

  swd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  swd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (in_q),
    .cfg_i       (cfg),
    .res_valid_o (res_vld),
    .res_o       (res)
  );

  assign advance    = in_vld_q
                   && ((in_q.op == swd_pkg::OP_START) || !out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_vld) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `SWD_ASSERT_IMP(a_done_busy, out_vld_q && out_q.transfer_done, out_q.busy_res)
  `SWD_ASSERT_IMP(a_release_low, out_vld_q && !out_q.drive_enable, !out_q.drive_level)
  `SWD_ASSERT_IMP(a_ack_on_done, out_vld_q && !out_q.transfer_done, out_q.ack_code == swd_pkg::ACK_NONE)
  `SWD_ASSERT_NXT(a_in_hold, in_vld_q && in_stall_o, in_vld_q && $stable(in_q))

endmodule

FILE: tb/swd_host_transfer_sequencer_unit_test.sv
// Self-checking testbench for the SWD host transfer sequencer: directed table then random transfers
`timescale 1ns / 1ps

module swd_host_transfer_sequencer_unit_test;

  localparam int HALF_PERIOD    = 6;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 8;
  localparam int HOLD_CYCLES    = 80;
  localparam int SEG_ITEMS      = 16;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PLAN_ROWS      = 25;

  localparam logic [swd_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [2:0] ACK_ALL_HIGH = 3'b111;
  localparam logic [2:0] ACK_MIXED    = 3'b011;

  // short names for the table
  localparam logic [2:0] A_NONE  = swd_pkg::ACK_NONE;
  localparam logic [2:0] A_OK    = swd_pkg::ACK_OK;
  localparam logic [2:0] A_WAIT  = swd_pkg::ACK_WAIT;
  localparam logic [2:0] A_FAULT = swd_pkg::ACK_FAULT;
  localparam logic [swd_pkg::CFG_IDX_W-1:0] R_TRN   = swd_pkg::CFG_TRN_CYCLES;
  localparam logic [swd_pkg::CFG_IDX_W-1:0] R_FORCE = swd_pkg::CFG_FORCE_DATA;
  localparam logic [swd_pkg::CFG_IDX_W-1:0] R_IDLE  = swd_pkg::CFG_IDLE_COUNT;

  // what an idle bus cycle looks like: line held low by the host
  localparam swd_pkg::out_t IDLE_BUS =
    '{1'b0, 1'b1, 1'b0, swd_pkg::ACK_NONE, 32'h0, 1'b0, 1'b0};

  typedef enum logic [1:0] {ROW_CLOCK, ROW_XFER, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e                       kind;
    logic [3:0]                      req;
    logic [31:0]                     word;
    logic [2:0]                      ack;
    logic [31:0]                     rdata;
    logic                            flip;
    logic                            poke;
    logic [swd_pkg::CFG_IDX_W-1:0]   cfg_idx;
    logic [7:0]                      cfg_val;
    logic                            has_exp;
  } row_t;

  // word holds the sampled line level on clock rows
  localparam row_t PLAN [PLAN_ROWS] = '{
    '{ROW_CLOCK, 4'h0, 32'h00000000, A_NONE, 32'h0, 1'b0, 1'b0, R_TRN, 8'h00, 1'b1},
    '{ROW_CLOCK, 4'h0, 32'h00000001, A_NONE, 32'h0, 1'b0, 1'b0, R_TRN, 8'h00, 1'b1},
    '{ROW_XFER, 4'h0, 32'h00000000, A_OK, 32'h00000000, 1'b0, 1'b0, R_TRN, 8'h00, 1'b0},
    '{ROW_XFER, 4'hF, 32'h00000000, A_OK, 32'hFFFFFFFF, 1'b0, 1'b0, R_TRN, 8'h00, 1'b0},
    '{ROW_XFER, 4'h2, 32'h00000000, A_OK, 32'h00000000, 1'b1, 1'b0, R_TRN, 8'h00, 1'b0},
    '{ROW_XFER, 4'hD, 32'hFFFFFFFF, A_OK, 32'h00000000, 1'b0, 1'b1, R_TRN, 8'h00, 1'b0},
    '{ROW_XFER, 4'h5, 32'h13579BDF, A_WAIT, 32'h0, 1'b0, 1'b0, R_TRN, 8'h00, 1'b0},
    '{ROW_XFER, 4'hA, 32'h00000000, A_FAULT, 32'h0F0F0F0F, 1'b0, 1'b0, R_TRN, 8'h00, 1'b0},
    '{ROW_XFER, 4'h9, 32'h2468ACE0, ACK_ALL_HIGH, 32'h0, 1'b0, 1'b0, R_TRN, 8'h00, 1'b0},
    '{ROW_XFER, 4'h6, 32'h00000000, A_NONE, 32'hFFFF0000, 1'b0, 1'b0, R_TRN, 8'h00, 1'b0},
    '{ROW_CFG, 4'h0, 32'h00000000, A_NONE, 32'h0, 1'b0, 1'b0, R_FORCE, 8'h01, 1'b0},
    '{ROW_XFER, 4'h1, 32'hA5A5A5A5, A_WAIT, 32'h0, 1'b0, 1'b0, R_TRN, 8'h00, 1'b0},
    '{ROW_XFER, 4'h3, 32'h00000000, A_FAULT, 32'h12345678, 1'b0, 1'b0, R_TRN, 8'h00, 1'b0},
    '{ROW_XFER, 4'h7, 32'h00000000, ACK_MIXED, 32'h87654321, 1'b0, 1'b0, R_TRN, 8'h00, 1'b0},
    '{ROW_CFG, 4'h0, 32'h00000000, A_NONE, 32'h0, 1'b0, 1'b0, R_TRN, 8'h00, 1'b0},
    '{ROW_XFER, 4'hE, 32'h00000000, A_OK, 32'h80000001, 1'b0, 1'b0, R_TRN, 8'h00, 1'b0},
    '{ROW_CFG, 4'h0, 32'h00000000, A_NONE, 32'h0, 1'b0, 1'b0, R_TRN, 8'h07, 1'b0},
    '{ROW_CFG, 4'h0, 32'h00000000, A_NONE, 32'h0, 1'b0, 1'b0, R_IDLE, 8'hFF, 1'b0},
    '{ROW_XFER, 4'hC, 32'h00000001, A_OK, 32'h0, 1'b0, 1'b0, R_TRN, 8'h00, 1'b0},
    '{ROW_CFG, 4'h0, 32'h00000000, A_NONE, 32'h0, 1'b0, 1'b0, CFG_SPARE, 8'hFF, 1'b0},
    '{ROW_CFG, 4'h0, 32'h00000000, A_NONE, 32'h0, 1'b0, 1'b0, R_TRN, 8'h04, 1'b0},
    '{ROW_CFG, 4'h0, 32'h00000000, A_NONE, 32'h0, 1'b0, 1'b0, R_IDLE, 8'h00, 1'b0},
    '{ROW_XFER, 4'h4, 32'h7FFFFFFF, A_OK, 32'h0, 1'b0, 1'b0, R_TRN, 8'h00, 1'b0},
    '{ROW_CFG, 4'h0, 32'h00000000, A_NONE, 32'h0, 1'b0, 1'b0, R_FORCE, 8'h00, 1'b0},
    '{ROW_CLOCK, 4'h0, 32'h00000001, A_NONE, 32'h0, 1'b0, 1'b0, R_TRN, 8'h00, 1'b1}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  swd_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  swd_pkg::out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [swd_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i = '0;

  swd_host_transfer_sequencer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // sequencer mirror, at reset values
  swd_pkg::cfg_t             seq_cfg     = '{swd_pkg::TRN_MIN, 1'b0, 8'h00};
  logic [3:0]                seq_phase   = swd_pkg::PH_IDLE;
  logic [swd_pkg::CNT_W-1:0] seq_bitcnt  = '0;
  logic [7:0]                seq_idlecnt = '0;
  logic [31:0]               seq_shift   = '0;
  logic [3:0]                seq_req     = '0;
  logic [2:0]                seq_ack     = swd_pkg::ACK_NONE;
  logic                      seq_par     = 1'b0;

  swd_pkg::out_t awaited_cycles [$];
  int fails = 0;
  int items_sent = 0;
  int cycles_checked = 0;
  int n_ok = 0, n_wait = 0, n_fault = 0, n_other = 0, n_parerr = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stuck = 0;
  bit typed_next = 1'b0;

  function automatic void goto_phase(input logic [3:0] p);
    seq_phase  = p;
    seq_bitcnt = '0;
  endfunction

  function automatic void finish_ok();
    goto_phase(seq_idlecnt != 0 ? swd_pkg::PH_IDLECYC : swd_pkg::PH_IDLE);
  endfunction

  // one SWCLK cycle of the host; returns 1 when the item yields a bus cycle
  function automatic bit predict_bus_cycle(input swd_pkg::in_t it,
                                           output swd_pkg::out_t res);
    logic [2:0] trn;
    logic [7:0] hdr;
    logic lvl, en, busy, done, rd, ok, wf, s;
    trn = seq_cfg.trn_len;
    if (trn < swd_pkg::TRN_MIN) trn = swd_pkg::TRN_MIN;
    if (trn > swd_pkg::TRN_MAX) trn = swd_pkg::TRN_MAX;
    lvl  = 1'b0;
    en   = 1'b0;
    busy = 1'b1;
    s    = it.line_sample;
    rd   = seq_req[1];
    res  = '0;
    if (it.op == swd_pkg::OP_START) begin
      if (seq_phase == swd_pkg::PH_IDLE) begin
        seq_req     = it.request_bits;
        seq_shift   = it.write_word;
        seq_par     = 1'b0;
        seq_ack     = swd_pkg::ACK_NONE;
        seq_idlecnt = seq_cfg.idle_count;
        goto_phase(swd_pkg::PH_REQ);
      end
      return 1'b0;
    end
    ok = (seq_ack == swd_pkg::ACK_OK);
    wf = (seq_ack == swd_pkg::ACK_WAIT) || (seq_ack == swd_pkg::ACK_FAULT);
    case (seq_phase)
      swd_pkg::PH_REQ: begin
        hdr = swd_pkg::HDR_BASE | {2'b00, ^seq_req, seq_req, 1'b0};
        en  = 1'b1;
        lvl = hdr[seq_bitcnt[2:0]];
        seq_bitcnt++;
        if (seq_bitcnt >= swd_pkg::REQ_BITS) goto_phase(swd_pkg::PH_TRN1);
      end
      swd_pkg::PH_TRN1: begin
        seq_bitcnt++;
        if (seq_bitcnt >= {3'b000, trn}) goto_phase(swd_pkg::PH_ACK);
      end
      swd_pkg::PH_ACK: begin
        seq_ack = {s, seq_ack[2:1]};
        seq_bitcnt++;
        if (seq_bitcnt >= swd_pkg::ACK_BITS) begin
          ok = (seq_ack == swd_pkg::ACK_OK);
          wf = (seq_ack == swd_pkg::ACK_WAIT) || (seq_ack == swd_pkg::ACK_FAULT);
          if (!rd) goto_phase(swd_pkg::PH_TRN2);
          else if (ok) goto_phase(swd_pkg::PH_RDATA);
          else if (wf) goto_phase(seq_cfg.force_data ? swd_pkg::PH_RDATA : swd_pkg::PH_TRN3);
          else goto_phase(swd_pkg::PH_RELEASE);
        end
      end
      swd_pkg::PH_TRN2: begin
        seq_bitcnt++;
        if (seq_bitcnt >= {3'b000, trn}) begin
          if (ok) goto_phase(swd_pkg::PH_WDATA);
          else if (wf) goto_phase(seq_cfg.force_data ? swd_pkg::PH_WDATA : swd_pkg::PH_IDLE);
          else goto_phase(swd_pkg::PH_RELEASE);
        end
      end
      swd_pkg::PH_WDATA: begin
        en = 1'b1;
        if (ok) begin
          if (seq_bitcnt < swd_pkg::DATA_BITS) begin
            lvl       = seq_shift[0];
            seq_par   = seq_par ^ lvl;
            seq_shift = seq_shift >> 1;
          end else begin
            lvl = seq_par;
          end
        end
        seq_bitcnt++;
        if (seq_bitcnt >= swd_pkg::FRAME_BITS) begin
          if (ok) finish_ok();
          else goto_phase(swd_pkg::PH_IDLE);
        end
      end
      swd_pkg::PH_RDATA: begin
        if (seq_bitcnt < swd_pkg::DATA_BITS) seq_shift = {s, seq_shift[31:1]};
        seq_par = seq_par ^ s;
        seq_bitcnt++;
        if (seq_bitcnt >= swd_pkg::FRAME_BITS) goto_phase(swd_pkg::PH_TRN3);
      end
      swd_pkg::PH_TRN3: begin
        seq_bitcnt++;
        if (seq_bitcnt >= {3'b000, trn}) begin
          if (ok) finish_ok();
          else goto_phase(swd_pkg::PH_IDLE);
        end
      end
      swd_pkg::PH_IDLECYC: begin
        en = 1'b1;
        if (seq_idlecnt != 0) seq_idlecnt--;
        if (seq_idlecnt == 0) goto_phase(swd_pkg::PH_IDLE);
      end
      swd_pkg::PH_RELEASE: begin
        seq_bitcnt++;
        if (seq_bitcnt >= swd_pkg::FRAME_BITS + {3'b000, trn}) goto_phase(swd_pkg::PH_IDLE);
      end
      default: begin
        seq_phase = swd_pkg::PH_IDLE;
        busy      = 1'b0;
        en        = 1'b1;
      end
    endcase
    done = busy && (seq_phase == swd_pkg::PH_IDLE);
    res.drive_level   = lvl;
    res.drive_enable  = en;
    res.transfer_done = done;
    res.ack_code      = done ? seq_ack : swd_pkg::ACK_NONE;
    res.read_word     = (done && rd && ok) ? seq_shift : 32'h0;
    res.parity_error  = (done && rd && ok) ? seq_par : 1'b0;
    res.busy_res      = busy;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    swd_pkg::out_t want;
    swd_pkg::out_t got;
    swd_pkg::out_t pred;
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        moved = 1'b1;
        got   = out_data_o;
        if (awaited_cycles.size() == 0) begin
          $error("bus cycle result with nothing awaited");
          fails++;
        end else begin
          want = awaited_cycles.pop_front();
          cycles_checked++;
          check_field("drive_level", 32'(want.drive_level), 32'(got.drive_level));
          check_field("drive_enable", 32'(want.drive_enable), 32'(got.drive_enable));
          check_field("transfer_done", 32'(want.transfer_done), 32'(got.transfer_done));
          check_field("ack_code", 32'(want.ack_code), 32'(got.ack_code));
          check_field("read_word", want.read_word, got.read_word);
          check_field("parity_error", 32'(want.parity_error), 32'(got.parity_error));
          check_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
        end
      end
      if (in_valid_i === 1'b1 && in_stall_o === 1'b0) begin
        moved = 1'b1;
        if (predict_bus_cycle(in_data_i, pred)) begin
          awaited_cycles.push_back(typed_next ? IDLE_BUS : pred);
          if (pred.transfer_done) begin
            case (pred.ack_code)
              swd_pkg::ACK_OK:    n_ok++;
              swd_pkg::ACK_WAIT:  n_wait++;
              swd_pkg::ACK_FAULT: n_fault++;
              default:            n_other++;
            endcase
            if (pred.parity_error) n_parerr++;
          end
        end
      end
      if (cfg_valid_i === 1'b1 && cfg_ready_o === 1'b1) begin
        moved = 1'b1;
        case (cfg_index_i)
          swd_pkg::CFG_TRN_CYCLES: seq_cfg.trn_len    = cfg_data_i[2:0];
          swd_pkg::CFG_FORCE_DATA: seq_cfg.force_data = cfg_data_i[0];
          swd_pkg::CFG_IDLE_COUNT: seq_cfg.idle_count = cfg_data_i;
          default: ;
        endcase
      end
      stuck = moved ? 0 : stuck + 1;
      if (stuck >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off whenever the sender asks
  always @(negedge clk_i) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // entered and left at a falling edge; valid stays high for a following item
  task automatic send_item(input swd_pkg::in_t it, input bit typed);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    if (it.op == swd_pkg::OP_CLOCK || seq_phase == swd_pkg::PH_IDLE) items_sent++;
    typed_next = typed;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (awaited_cycles.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [swd_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // a target that answers with the given ack and read data
  task automatic run_transfer(input logic [3:0] req, input logic [31:0] word,
                              input logic [2:0] ack, input logic [31:0] rdata,
                              input logic flip, input int poke_at);
    swd_pkg::in_t it;
    int k;
    it.op           = swd_pkg::OP_START;
    it.request_bits = req;
    it.write_word   = word;
    it.line_sample  = 1'($urandom_range(1));
    send_item(it, 1'b0);
    k = 0;
    while (seq_phase != swd_pkg::PH_IDLE) begin
      if (k == poke_at) begin
        it.op           = swd_pkg::OP_START;
        it.request_bits = 4'($urandom_range(15));
        it.write_word   = $urandom;
        send_item(it, 1'b0);
      end
      it.op           = swd_pkg::OP_CLOCK;
      it.request_bits = 4'($urandom_range(15));
      it.write_word   = $urandom;
      case (seq_phase)
        swd_pkg::PH_ACK:   it.line_sample = ack[seq_bitcnt[1:0]];
        swd_pkg::PH_RDATA: it.line_sample = (seq_bitcnt < swd_pkg::DATA_BITS)
                                            ? rdata[seq_bitcnt[4:0]]
                                            : (^rdata) ^ flip;
        default:           it.line_sample = 1'($urandom_range(1));
      endcase
      send_item(it, 1'b0);
      k++;
    end
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'h0;
      1:       return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    swd_pkg::in_t it;
    int seg_base;
    logic [2:0] trn_set;
    logic force_set;
    logic [7:0] idle_set;
    logic [7:0] cfg_word;
    logic [2:0] ack_pick;
    int hold_now;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < PLAN_ROWS; i++) begin
      case (PLAN[i].kind)
        ROW_CLOCK: begin
          it.op           = swd_pkg::OP_CLOCK;
          it.request_bits = 4'h0;
          it.write_word   = 32'h0;
          it.line_sample  = PLAN[i].word[0];
          send_item(it, PLAN[i].has_exp);
        end
        ROW_XFER: begin
          run_transfer(PLAN[i].req, PLAN[i].word, PLAN[i].ack, PLAN[i].rdata,
                       PLAN[i].flip, PLAN[i].poke ? 2 : -1);
        end
        default: begin
          settle_block();
          write_reg(PLAN[i].cfg_idx, PLAN[i].cfg_val);
        end
      endcase
    end

    for (int seg = 0; seg < 6; seg++) begin
      trn_set   = 3'($urandom_range(7));
      force_set = 1'($urandom_range(1));
      idle_set  = 8'($urandom_range(4));
      hold_now  = 0;
      case (seg)
        0: begin
          trn_set = swd_pkg::TRN_MIN; force_set = 1'b0; idle_set = 8'd0; hold_now = 1;
        end
        2: begin
          trn_set = swd_pkg::TRN_MAX; force_set = 1'b1; idle_set = 8'd2; hold_now = 1;
        end
        4: begin trn_set = 3'd2; force_set = 1'b0; idle_set = 8'd1; end
        default: ;
      endcase
      // transfers all done before the registers move
      settle_block();
      cfg_word = 8'($urandom);
      cfg_word[2:0] = trn_set;
      write_reg(swd_pkg::CFG_TRN_CYCLES, cfg_word);
      cfg_word = 8'($urandom);
      cfg_word[0] = force_set;
      write_reg(swd_pkg::CFG_FORCE_DATA, cfg_word);
      write_reg(swd_pkg::CFG_IDLE_COUNT, idle_set);
      @(posedge clk_i);
      gap_pct   = (seg < 2) ? 31 : (seg < 4) ? 79 : 0;
      stall_pct = (seg < 2) ? 79 : (seg < 4) ? 31 : 0;
      if (hold_now != 0) hold_token++;
      @(negedge clk_i);

      seg_base = items_sent;
      while (items_sent - seg_base < SEG_ITEMS) begin
        if ($urandom_range(99) < 12) begin
          repeat ($urandom_range(1, 4)) begin
            it.op           = swd_pkg::OP_CLOCK;
            it.request_bits = 4'($urandom_range(15));
            it.write_word   = $urandom;
            it.line_sample  = 1'($urandom_range(1));
            send_item(it, 1'b0);
          end
        end else begin
          case ($urandom_range(9))
            0, 1, 2, 3, 4: ack_pick = swd_pkg::ACK_OK;
            5:             ack_pick = swd_pkg::ACK_WAIT;
            6:             ack_pick = swd_pkg::ACK_FAULT;
            7:             ack_pick = swd_pkg::ACK_NONE;
            default:       ack_pick = 3'($urandom_range(7));
          endcase
          run_transfer(4'($urandom_range(15)), pick_word(), ack_pick, pick_word(),
                       $urandom_range(4) == 0,
                       ($urandom_range(9) == 0) ? int'($urandom_range(40)) : -1);
        end
      end
    end

    in_valid_i <= 1'b0;
    while (awaited_cycles.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (awaited_cycles.size() != 0) fails++;

    $display("%0d items taken, %0d bus cycles compared across six register settings",
             items_sent, cycles_checked);
    $display("transfers ended OK %0d, WAIT %0d, FAULT %0d, other ack %0d; parity errors %0d",
             n_ok, n_wait, n_fault, n_other, n_parerr);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
